// ----- sv/arpb_pkg.sv -----
// Shared types and constants of the audio record and playback buffer.
package arpb_pkg;

	localparam int MEM_DEPTH = 65536;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int PTR_W     = ADDR_W + 1;
	localparam int SAMPLE_W  = 16;
	localparam int LEN_W     = 17;
	localparam int OP_W      = 3;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REC  = 2'd1,
		MODE_PLAY = 2'd2
	} mode_t;

	typedef enum logic [OP_W-1:0] {
		OP_REC_TOGGLE  = 3'd0,
		OP_PLAY_TOGGLE = 3'd1,
		OP_REWIND      = 3'd2,
		OP_SAMPLE_IN   = 3'd3,
		OP_SAMPLE_REQ  = 3'd4
	} op_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
	} mem_cmd_t;

	typedef struct packed {
		logic             sample_valid;
		mode_t            mode;
		logic [LEN_W-1:0] length;
	} res_info_t;

endpackage

// ----- sv/arpb_ram.sv -----
// Generic single-port RAM with registered read data.
module arpb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ----- sv/arpb_ctrl.sv -----
// Mode, pointer and length registers with the per-request update logic.
module arpb_ctrl import arpb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [OP_W-1:0] operation,
	output mem_cmd_t        mem_cmd,
	output res_info_t       res
);

	mode_t            mode_q, mode_d;
	logic [PTR_W-1:0] rec_ptr_q, rec_ptr_d;
	logic [PTR_W-1:0] play_ptr_q, play_ptr_d;
	logic [PTR_W-1:0] size_q, size_d;
	logic             rec_room;
	logic             play_more;

	assign rec_room  = rec_ptr_q < PTR_W'(MEM_DEPTH);
	assign play_more = (play_ptr_q < size_q) && (play_ptr_q < PTR_W'(MEM_DEPTH));

	always_comb begin
		mode_d       = mode_q;
		rec_ptr_d    = rec_ptr_q;
		play_ptr_d   = play_ptr_q;
		size_d       = size_q;
		mem_cmd.en   = 1'b0;
		mem_cmd.we   = 1'b0;
		mem_cmd.addr = play_ptr_q[ADDR_W-1:0];
		res.sample_valid = 1'b0;
		if (accept) begin
			case (operation)
				OP_REC_TOGGLE: begin
					if (mode_q == MODE_REC) begin
						mode_d = MODE_IDLE;
						size_d = rec_ptr_q;
					end else begin
						mode_d    = MODE_REC;
						rec_ptr_d = '0;
					end
					play_ptr_d = '0;
				end
				OP_PLAY_TOGGLE: begin
					mode_d = (mode_q == MODE_PLAY) ? MODE_IDLE : MODE_PLAY;
				end
				OP_REWIND: begin
					play_ptr_d = '0;
				end
				OP_SAMPLE_IN: begin
					if (mode_q == MODE_REC) begin
						if (rec_room) begin
							mem_cmd.en   = 1'b1;
							mem_cmd.we   = 1'b1;
							mem_cmd.addr = rec_ptr_q[ADDR_W-1:0];
							rec_ptr_d    = rec_ptr_q + PTR_W'(1);
							size_d       = rec_ptr_q + PTR_W'(1);
						end else begin
							size_d = PTR_W'(MEM_DEPTH);
							mode_d = MODE_IDLE;
						end
					end
				end
				OP_SAMPLE_REQ: begin
					if (mode_q == MODE_PLAY) begin
						if (play_more) begin
							mem_cmd.en       = 1'b1;
							res.sample_valid = 1'b1;
							play_ptr_d       = play_ptr_q + PTR_W'(1);
						end else begin
							mode_d     = MODE_IDLE;
							play_ptr_d = '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
		res.mode   = mode_d;
		res.length = LEN_W'(size_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			rec_ptr_q  <= '0;
			play_ptr_q <= '0;
			size_q     <= '0;
		end else begin
			mode_q     <= mode_d;
			rec_ptr_q  <= rec_ptr_d;
			play_ptr_q <= play_ptr_d;
			size_q     <= size_d;
		end
	end

endmodule

// ----- sv/audio_record_playback_buffer.sv -----
// Top level of the audio record and playback buffer.
//
// Each request on the slave stream carries an operation code in s_tuser
// and a sample in s_tdata. Every request produces exactly one result on the
// master stream: the played sample, the mode after the request and the
// recorded length in m_tdata, and a sample valid flag in m_tuser.
// A request is decoded against the mode and pointer registers in the cycle
// it is accepted, which also issues its sample memory access, if it has
// one. Stage one then holds the request while the registered memory read
// completes, and the output register presents the result. One request is
// accepted every cycle while the receiver does not stall; the single memory
// port, shared by writes while recording and reads while playing, sets
// that rate. When the receiver stalls, the output register and stage one
// fill and s_tready drops until the result is taken. Reset returns the
// block to idle with all pointers and the length at zero and both stages
// empty; the memory contents are not cleared.
module audio_record_playback_buffer import arpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // sample_in
	input  logic [2:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // sample_out, mode_now, recorded_length, zero fill
	output logic        m_tuser   // sample_valid
);

	logic                accept;
	logic                out_free;
	mem_cmd_t            mem_cmd;
	res_info_t           res;
	logic                valid_s1;
	res_info_t           res_s1;
	logic [SAMPLE_W-1:0] rdata;
	logic [SAMPLE_W-1:0] sample_q;
	res_info_t           res_q;

	assign out_free = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	arpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (s_tuser),
		.mem_cmd   (mem_cmd),
		.res       (res)
	);

	arpb_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (mem_cmd.en),
		.we    (mem_cmd.we),
		.addr  (mem_cmd.addr),
		.wdata (s_tdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			res_q    <= res_s1;
			sample_q <= res_s1.sample_valid ? rdata : '0;
		end
	end

	assign m_tdata = {5'd0, res_q.length, res_q.mode, sample_q};
	assign m_tuser = res_q.sample_valid;

	a_valid_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.sample_valid |-> res_q.mode == MODE_PLAY)
		else $error("played sample reported outside play mode");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_q.length <= LEN_W'(MEM_DEPTH))
		else $error("recorded length beyond memory depth");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid && !m_tready |=> valid_s1 && $stable(res_s1))
		else $error("stage one lost a request during a stall");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.sample_valid |-> sample_q == '0)
		else $error("nonzero sample without sample valid");

endmodule
